// ----- src/dcm_ramp_pkg.sv -----
`default_nettype none

package dcm_ramp_pkg;

	// Event codes carried in the operation field.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_GO    = 2'd1;
	localparam logic [1:0] OP_SOFT  = 2'd2;
	localparam logic [1:0] OP_ESTOP = 2'd3;

	// Motor phase codes, also reported as motor_state.
	localparam logic [1:0] PH_STOPPED  = 2'd0;
	localparam logic [1:0] PH_UP       = 2'd1;
	localparam logic [1:0] PH_DOWN     = 2'd2;
	localparam logic [1:0] PH_AT_SPEED = 2'd3;

	// Run status codes.
	localparam logic [1:0] ST_OKAY        = 2'd0;
	localparam logic [1:0] ST_LOWER_LIMIT = 2'd1;
	localparam logic [1:0] ST_UPPER_LIMIT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_RAMP_SETTING = 2'd0;
	localparam logic [1:0] REG_LOWER_ENABLE = 2'd1;
	localparam logic [1:0] REG_UPPER_ENABLE = 2'd2;

	// Direction codes.
	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	// Ramp timing and speed scaling.
	localparam logic [14:0] PERIOD_UNIT  = 15'd2000;
	localparam logic [3:0]  MAX_RAMP     = 4'd9;
	localparam logic [3:0]  RAMP_RESET   = 4'd4;
	localparam int          PERCENT_MAX  = 100;
	localparam int          PERCENT_CODES = 128;

	// Speed percent to drive level lookup.
	typedef logic [7:0] level_table_t [0:PERCENT_CODES-1];

	// One input event.
	typedef struct packed {
		logic [1:0] operation;
		logic       go_direction;
		logic [6:0] speed_percent;
		logic       lower_switch_hit;
		logic       upper_switch_hit;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [7:0] first_drive_level;
		logic [7:0] second_drive_level;
		logic [1:0] motor_state;
		logic [1:0] run_status;
		logic       motor_direction;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/dc_motor_soft_start_ramp_core.sv -----
`default_nettype none

// Soft-start ramp controller for an H-bridge driven DC motor. Each accepted
// transaction is one event (a one-microsecond tick with the limit switch levels,
// a go command, a soft stop or an emergency stop) and produces exactly one result
// with both bridge drive levels, the motor state, the run status and the
// direction. The block takes one event per clock unless the input side stalls: an
// event is held in an input register, the whole state update is one short
// combinational pass, and the result is registered in the output register once
// that register is free. The input side stalls only while both the input
// register and a waiting result are held. Configuration writes are always ready
// and take effect on the next event.
module dc_motor_soft_start_ramp_core #(
	parameter int FULL_SCALE_LEVEL = 250
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// Event channel.
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire dcm_ramp_pkg::req_t req,
	// Result channel.
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output dcm_ramp_pkg::rsp_t  rsp,
	// Configuration write channel.
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [3:0]          cfg_data
);

	// Build the percent to level table at elaboration.
	function automatic dcm_ramp_pkg::level_table_t build_levels();
		dcm_ramp_pkg::level_table_t t;
		int pct;
		for (int i = 0; i < dcm_ramp_pkg::PERCENT_CODES; i++) begin
			pct = (i > dcm_ramp_pkg::PERCENT_MAX) ? dcm_ramp_pkg::PERCENT_MAX : i;
			t[i] = 8'((pct * FULL_SCALE_LEVEL) / dcm_ramp_pkg::PERCENT_MAX);
		end
		return t;
	endfunction

	localparam dcm_ramp_pkg::level_table_t LEVEL_TABLE = build_levels();

	// Configuration registers.
	logic [3:0] ramp_q;
	logic       lower_en_q;
	logic       upper_en_q;

	// Motor state.
	logic [1:0]  phase_q;
	logic [7:0]  level_q;
	logic [7:0]  goal_q;
	logic        heading_q;
	logic [14:0] count_q;
	logic        rev_q;
	logic        rev_dir_q;
	logic [7:0]  rev_level_q;

	// Pipeline registers.
	dcm_ramp_pkg::req_t req_s1;
	logic               req_vld_s1;
	dcm_ramp_pkg::rsp_t rsp_q;
	logic               rsp_valid_q;

	logic rsp_free;
	logic s1_adv;
	logic req_take;

	// Next state from the combinational pass.
	logic [1:0]  phase_n;
	logic [7:0]  level_n;
	logic [7:0]  goal_n;
	logic        heading_n;
	logic [14:0] count_n;
	logic        rev_n;
	logic        rev_dir_n;
	logic [7:0]  rev_level_n;
	logic [1:0]  status_n;
	logic        start_req;
	logic        start_dir;
	logic [7:0]  start_level;
	logic [7:0]  go_level;
	logic [7:0]  step_level;
	logic [14:0] step_reload;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Handshake: the input register moves on when the result register is free.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = req_vld_s1 && rsp_free;
	assign req_stall = req_vld_s1 && !rsp_free;
	assign req_take  = req_valid && !req_stall;

	// Configuration writes; an out-of-range ramp setting is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q     <= dcm_ramp_pkg::RAMP_RESET;
			lower_en_q <= 1'b0;
			upper_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dcm_ramp_pkg::REG_RAMP_SETTING: begin
					if (cfg_data <= dcm_ramp_pkg::MAX_RAMP) begin
						ramp_q <= cfg_data;
					end
				end
				dcm_ramp_pkg::REG_LOWER_ENABLE: lower_en_q <= cfg_data[0];
				dcm_ramp_pkg::REG_UPPER_ENABLE: upper_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Countdown reload after a ramp step: period minus the step tick itself.
	assign step_reload = ({11'd0, ramp_q} * dcm_ramp_pkg::PERIOD_UNIT)
		+ dcm_ramp_pkg::PERIOD_UNIT - 15'd1;

	assign go_level = LEVEL_TABLE[req_s1.speed_percent];

	// Level after one ramp step toward the goal.
	always_comb begin
		if (level_q < goal_q) begin
			step_level = level_q + 8'd1;
		end else if (level_q > goal_q) begin
			step_level = level_q - 8'd1;
		end else begin
			step_level = level_q;
		end
	end

	// Event handling. A start from stop is always the last action of a path,
	// so it is flagged here and applied after the case.
	always_comb begin
		phase_n     = phase_q;
		level_n     = level_q;
		goal_n      = goal_q;
		heading_n   = heading_q;
		count_n     = count_q;
		rev_n       = rev_q;
		rev_dir_n   = rev_dir_q;
		rev_level_n = rev_level_q;
		status_n    = dcm_ramp_pkg::ST_OKAY;
		start_req   = 1'b0;
		start_dir   = req_s1.go_direction;
		start_level = go_level;

		case (req_s1.operation)
			dcm_ramp_pkg::OP_TICK: begin
				if (phase_q != dcm_ramp_pkg::PH_STOPPED) begin
					if (lower_en_q && req_s1.lower_switch_hit) begin
						level_n  = 8'd0;
						phase_n  = dcm_ramp_pkg::PH_STOPPED;
						rev_n    = 1'b0;
						status_n = dcm_ramp_pkg::ST_LOWER_LIMIT;
					end else if (upper_en_q && req_s1.upper_switch_hit) begin
						level_n  = 8'd0;
						phase_n  = dcm_ramp_pkg::PH_STOPPED;
						rev_n    = 1'b0;
						status_n = dcm_ramp_pkg::ST_UPPER_LIMIT;
					end else if (phase_q != dcm_ramp_pkg::PH_AT_SPEED) begin
						if (count_q != 15'd0) begin
							count_n = count_q - 15'd1;
						end else begin
							level_n = step_level;
							if (step_level == goal_q) begin
								if (goal_q != 8'd0) begin
									phase_n = dcm_ramp_pkg::PH_AT_SPEED;
								end else begin
									phase_n = dcm_ramp_pkg::PH_STOPPED;
									if (rev_q) begin
										rev_n       = 1'b0;
										start_req   = 1'b1;
										start_dir   = rev_dir_q;
										start_level = rev_level_q;
									end
								end
							end else begin
								count_n = step_reload;
							end
						end
					end
				end
			end
			dcm_ramp_pkg::OP_GO: begin
				if (phase_q == dcm_ramp_pkg::PH_STOPPED) begin
					rev_n     = 1'b0;
					start_req = 1'b1;
				end else if (req_s1.go_direction == heading_q) begin
					rev_n  = 1'b0;
					goal_n = go_level;
					if (go_level > level_q) begin
						phase_n = dcm_ramp_pkg::PH_UP;
					end else if (go_level < level_q) begin
						phase_n = dcm_ramp_pkg::PH_DOWN;
					end else if (go_level == 8'd0) begin
						phase_n = dcm_ramp_pkg::PH_STOPPED;
					end else begin
						phase_n = dcm_ramp_pkg::PH_AT_SPEED;
					end
				end else begin
					// Reversal: ramp down first unless already on the way down.
					if (!rev_q) begin
						if (level_q == 8'd0) begin
							phase_n = dcm_ramp_pkg::PH_STOPPED;
						end else begin
							goal_n  = 8'd0;
							count_n = 15'd0;
							phase_n = dcm_ramp_pkg::PH_DOWN;
						end
					end
					if (go_level == 8'd0) begin
						rev_n = 1'b0;
					end else if (phase_n == dcm_ramp_pkg::PH_STOPPED) begin
						start_req = 1'b1;
					end else begin
						rev_n       = 1'b1;
						rev_dir_n   = req_s1.go_direction;
						rev_level_n = go_level;
					end
				end
			end
			dcm_ramp_pkg::OP_SOFT: begin
				rev_n = 1'b0;
				if (phase_q != dcm_ramp_pkg::PH_STOPPED) begin
					if (level_q == 8'd0) begin
						phase_n = dcm_ramp_pkg::PH_STOPPED;
					end else begin
						goal_n  = 8'd0;
						count_n = 15'd0;
						phase_n = dcm_ramp_pkg::PH_DOWN;
					end
				end
			end
			dcm_ramp_pkg::OP_ESTOP: begin
				level_n = 8'd0;
				phase_n = dcm_ramp_pkg::PH_STOPPED;
				rev_n   = 1'b0;
			end
			default: ;
		endcase

		// Start from stop; a zero level leaves the motor stopped.
		if (start_req && (start_level != 8'd0)) begin
			heading_n = start_dir;
			level_n   = 8'd0;
			goal_n    = start_level;
			count_n   = 15'd0;
			phase_n   = dcm_ramp_pkg::PH_UP;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req_take) begin
			req_vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			req_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	// Motor state update, once per event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dcm_ramp_pkg::PH_STOPPED;
			level_q     <= 8'd0;
			goal_q      <= 8'd0;
			heading_q   <= dcm_ramp_pkg::DIR_CW;
			count_q     <= 15'd0;
			rev_q       <= 1'b0;
			rev_dir_q   <= dcm_ramp_pkg::DIR_CW;
			rev_level_q <= 8'd0;
		end else if (s1_adv) begin
			phase_q     <= phase_n;
			level_q     <= level_n;
			goal_q      <= goal_n;
			heading_q   <= heading_n;
			count_q     <= count_n;
			rev_q       <= rev_n;
			rev_dir_q   <= rev_dir_n;
			rev_level_q <= rev_level_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.first_drive_level  <= (heading_n == dcm_ramp_pkg::DIR_CCW) ? level_n : 8'd0;
			rsp_q.second_drive_level <= (heading_n == dcm_ramp_pkg::DIR_CW) ? level_n : 8'd0;
			rsp_q.motor_state        <= phase_n;
			rsp_q.run_status         <= status_n;
			rsp_q.motor_direction    <= heading_n;
		end
	end

	// A stopped motor carries no drive.
	a_stopped_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dcm_ramp_pkg::PH_STOPPED) |-> (level_q == 8'd0))
		else $error("stopped with nonzero drive level");

	// At speed means the goal has been reached and is not zero.
	a_at_speed_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dcm_ramp_pkg::PH_AT_SPEED) |-> ((level_q == goal_q) && (goal_q != 8'd0)))
		else $error("at speed without reaching a nonzero goal");

	// A pending reversal only exists while ramping down toward zero.
	a_reversal_ramps_down: assert property (@(posedge clk) disable iff (!arst_n)
		rev_q |-> ((phase_q == dcm_ramp_pkg::PH_DOWN) && (goal_q == 8'd0)
			&& (rev_level_q != 8'd0)))
		else $error("reversal pending outside a ramp down");

	// A limit stop is reported together with a stopped, undriven motor.
	a_limit_stop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.run_status != dcm_ramp_pkg::ST_OKAY))
		|-> ((rsp_q.motor_state == dcm_ramp_pkg::PH_STOPPED)
			&& (rsp_q.first_drive_level == 8'd0) && (rsp_q.second_drive_level == 8'd0)))
		else $error("limit stop reported with motor still driven");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_SCALE = 250;
	localparam int QUIET_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;

	// Register index with no register behind it.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dcm_ramp_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dcm_ramp_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	dc_motor_soft_start_ramp_core #(
		.FULL_SCALE_LEVEL(FULL_SCALE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Motor state as the testbench expects it to be.
	logic [1:0]  m_phase = dcm_ramp_pkg::PH_STOPPED;
	logic [7:0]  m_level = '0;
	logic [7:0]  m_goal = '0;
	logic        m_heading = dcm_ramp_pkg::DIR_CW;
	logic [14:0] m_countdown = '0;
	logic        m_rev_pending = 1'b0;
	logic        m_rev_heading = dcm_ramp_pkg::DIR_CW;
	logic [7:0]  m_rev_level = '0;
	logic [3:0]  m_ramp_sel = dcm_ramp_pkg::RAMP_RESET;
	logic        m_low_en = 1'b0;
	logic        m_up_en = 1'b0;

	// Expected drive reports, oldest first.
	dcm_ramp_pkg::rsp_t drive_report_q[$];

	int fault_count = 0;
	bit idling = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;

	function automatic logic [7:0] pct_to_level(logic [6:0] pct);
		int p;
		p = (int'(pct) > dcm_ramp_pkg::PERCENT_MAX) ? dcm_ramp_pkg::PERCENT_MAX : int'(pct);
		return 8'((p * FULL_SCALE) / dcm_ramp_pkg::PERCENT_MAX);
	endfunction

	function automatic void spin_up(logic dir, logic [7:0] lvl);
		if (lvl == 8'd0) return;
		m_heading = dir;
		m_level = '0;
		m_goal = lvl;
		m_countdown = '0;
		m_phase = dcm_ramp_pkg::PH_UP;
	endfunction

	function automatic void cut_power();
		m_level = '0;
		m_phase = dcm_ramp_pkg::PH_STOPPED;
		m_rev_pending = 1'b0;
	endfunction

	function automatic void wind_down();
		if (m_phase == dcm_ramp_pkg::PH_STOPPED) return;
		if (m_level == 8'd0) begin
			m_phase = dcm_ramp_pkg::PH_STOPPED;
			return;
		end
		m_goal = '0;
		m_countdown = '0;
		m_phase = dcm_ramp_pkg::PH_DOWN;
	endfunction

	function automatic void retarget(logic [7:0] lvl);
		m_goal = lvl;
		if (lvl > m_level)
			m_phase = dcm_ramp_pkg::PH_UP;
		else if (lvl < m_level)
			m_phase = dcm_ramp_pkg::PH_DOWN;
		else
			m_phase = (lvl == 8'd0) ? dcm_ramp_pkg::PH_STOPPED : dcm_ramp_pkg::PH_AT_SPEED;
	endfunction

	function automatic void handle_go(logic dir, logic [6:0] pct);
		logic [7:0] lvl;
		lvl = pct_to_level(pct);
		if (m_phase == dcm_ramp_pkg::PH_STOPPED) begin
			m_rev_pending = 1'b0;
			spin_up(dir, lvl);
			return;
		end
		if (dir == m_heading) begin
			m_rev_pending = 1'b0;
			retarget(lvl);
			return;
		end
		// Opposite direction: ramp down first, unless already doing so for a reversal.
		if (!m_rev_pending) wind_down();
		if (lvl == 8'd0) begin
			m_rev_pending = 1'b0;
			return;
		end
		if (m_phase == dcm_ramp_pkg::PH_STOPPED) begin
			spin_up(dir, lvl);
			return;
		end
		m_rev_pending = 1'b1;
		m_rev_heading = dir;
		m_rev_level = lvl;
	endfunction

	function automatic logic [1:0] tick_motor(logic low_hit, logic up_hit);
		if (m_phase == dcm_ramp_pkg::PH_STOPPED) return dcm_ramp_pkg::ST_OKAY;
		if (m_low_en && low_hit) begin
			cut_power();
			return dcm_ramp_pkg::ST_LOWER_LIMIT;
		end
		if (m_up_en && up_hit) begin
			cut_power();
			return dcm_ramp_pkg::ST_UPPER_LIMIT;
		end
		if (m_phase == dcm_ramp_pkg::PH_AT_SPEED) return dcm_ramp_pkg::ST_OKAY;
		if (m_countdown != 15'd0) begin
			m_countdown = m_countdown - 15'd1;
			return dcm_ramp_pkg::ST_OKAY;
		end
		if (m_level < m_goal)
			m_level = m_level + 8'd1;
		else if (m_level > m_goal)
			m_level = m_level - 8'd1;
		if (m_level == m_goal) begin
			if (m_goal != 8'd0) begin
				m_phase = dcm_ramp_pkg::PH_AT_SPEED;
			end else begin
				m_phase = dcm_ramp_pkg::PH_STOPPED;
				// The ramp down of a reversal is done: start the other way.
				if (m_rev_pending) begin
					m_rev_pending = 1'b0;
					spin_up(m_rev_heading, m_rev_level);
				end
			end
		end else begin
			m_countdown = 15'(int'(dcm_ramp_pkg::PERIOD_UNIT) * int'(m_ramp_sel)
				+ int'(dcm_ramp_pkg::PERIOD_UNIT) - 1);
		end
		return dcm_ramp_pkg::ST_OKAY;
	endfunction

	// Update the motor state for one event and return the report it should give.
	function automatic dcm_ramp_pkg::rsp_t advance_motor(dcm_ramp_pkg::req_t ev);
		dcm_ramp_pkg::rsp_t r;
		logic [1:0] status;
		status = dcm_ramp_pkg::ST_OKAY;
		case (ev.operation)
			dcm_ramp_pkg::OP_TICK: begin
				status = tick_motor(ev.lower_switch_hit, ev.upper_switch_hit);
			end
			dcm_ramp_pkg::OP_GO: begin
				handle_go(ev.go_direction, ev.speed_percent);
			end
			dcm_ramp_pkg::OP_SOFT: begin
				m_rev_pending = 1'b0;
				wind_down();
			end
			dcm_ramp_pkg::OP_ESTOP: begin
				cut_power();
			end
			default: ;
		endcase
		r.first_drive_level = (m_heading == dcm_ramp_pkg::DIR_CCW) ? m_level : 8'd0;
		r.second_drive_level = (m_heading == dcm_ramp_pkg::DIR_CW) ? m_level : 8'd0;
		r.motor_state = m_phase;
		r.run_status = status;
		r.motor_direction = m_heading;
		return r;
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [3:0] data);
		case (idx)
			dcm_ramp_pkg::REG_RAMP_SETTING: if (data <= dcm_ramp_pkg::MAX_RAMP) m_ramp_sel = data;
			dcm_ramp_pkg::REG_LOWER_ENABLE: m_low_en = data[0];
			dcm_ramp_pkg::REG_UPPER_ENABLE: m_up_en = data[0];
			default: ;
		endcase
	endfunction

	// Sender gaps: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (!idling) return 0;
		r = $urandom_range(0, 99);
		if (r < 85) return 0;
		if (r < 98) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic dcm_ramp_pkg::req_t make_cmd(logic [1:0] op);
		dcm_ramp_pkg::req_t ev;
		ev = 12'($urandom);
		ev.operation = op;
		return ev;
	endfunction

	// Switches fire rarely while a limit is armed, otherwise at random.
	function automatic dcm_ramp_pkg::req_t random_tick();
		dcm_ramp_pkg::req_t ev;
		ev = make_cmd(dcm_ramp_pkg::OP_TICK);
		if (m_low_en || m_up_en) begin
			ev.lower_switch_hit = ($urandom_range(0, 63) == 0);
			ev.upper_switch_hit = ($urandom_range(0, 63) == 0);
		end
		return ev;
	endfunction

	// Send one event and record the report it should produce.
	task automatic send_event(dcm_ramp_pkg::req_t ev);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= ev;
		do @(posedge clk); while (req_stall !== 1'b0);
		drive_report_q.push_back(advance_motor(ev));
	endtask

	task automatic issue(logic [1:0] op, logic dir, logic [6:0] pct);
		dcm_ramp_pkg::req_t ev;
		ev = make_cmd(op);
		ev.go_direction = dir;
		ev.speed_percent = pct;
		send_event(ev);
	endtask

	task automatic tick_with(logic low_hit, logic up_hit);
		dcm_ramp_pkg::req_t ev;
		ev = make_cmd(dcm_ramp_pkg::OP_TICK);
		ev.lower_switch_hit = low_hit;
		ev.upper_switch_hit = up_hit;
		send_event(ev);
	endtask

	task automatic tick_burst(int n);
		repeat (n) send_event(random_tick());
	endtask

	// Stop sending and wait for every outstanding report.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (drive_report_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_cfg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Events while stopped: all of them leave the motor at rest.
	task automatic test_idle_events();
		tick_with(1'b1, 1'b1);
		issue(dcm_ramp_pkg::OP_ESTOP, dcm_ramp_pkg::DIR_CW, 7'd50);
		issue(dcm_ramp_pkg::OP_SOFT, dcm_ramp_pkg::DIR_CCW, 7'd50);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd0);
	endtask

	// Go commands, clamping, reversals and their cancellation.
	task automatic test_commands();
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd127);
		tick_with(1'b1, 1'b0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd0);
		tick_with(1'b0, 1'b1);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd2);
		tick_with(1'b0, 1'b0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd100);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd3);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd5);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd1);
		issue(dcm_ramp_pkg::OP_SOFT, dcm_ramp_pkg::DIR_CW, 7'd0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd2);
		tick_with(1'b0, 1'b0);
		tick_with(1'b0, 1'b0);
		issue(dcm_ramp_pkg::OP_ESTOP, dcm_ramp_pkg::DIR_CCW, 7'd127);
		// A zero-level go while ramping up from zero stops the motor.
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd40);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd0);
		// A soft stop at level zero stops at once.
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd40);
		issue(dcm_ramp_pkg::OP_SOFT, dcm_ramp_pkg::DIR_CW, 7'd0);
	endtask

	// Limit switches stop the motor only when armed, lower one first.
	task automatic test_limit_switches();
		write_reg(dcm_ramp_pkg::REG_LOWER_ENABLE, 4'd1);
		write_reg(dcm_ramp_pkg::REG_UPPER_ENABLE, 4'd1);
		write_reg(REG_UNUSED, 4'hf);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd50);
		tick_with(1'b1, 1'b1);
		tick_with(1'b1, 1'b1);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd50);
		tick_with(1'b0, 1'b0);
		tick_with(1'b0, 1'b1);
		write_reg(dcm_ramp_pkg::REG_LOWER_ENABLE, 4'd0);
		write_reg(dcm_ramp_pkg::REG_UPPER_ENABLE, 4'd0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 50);
		tick_with(1'b1, 1'b1);
		issue(dcm_ramp_pkg::OP_ESTOP, dcm_ramp_pkg::DIR_CCW, 7'd0);
	endtask

	// Countdown start after a go and a soft stop, reversal hand-over and ramp writes.
	task automatic test_ramp_timing();
		write_reg(dcm_ramp_pkg::REG_RAMP_SETTING, 4'd0);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd1);
		tick_burst(3);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd1);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CCW, 7'd4);
		tick_burst(3);
		issue(dcm_ramp_pkg::OP_SOFT, dcm_ramp_pkg::DIR_CW, 7'd0);
		tick_burst(2);
		write_reg(dcm_ramp_pkg::REG_RAMP_SETTING, 4'd9);
		write_reg(dcm_ramp_pkg::REG_RAMP_SETTING, 4'd15);
		write_reg(dcm_ramp_pkg::REG_RAMP_SETTING, 4'd10);
		issue(dcm_ramp_pkg::OP_GO, dcm_ramp_pkg::DIR_CW, 7'd3);
		tick_burst(5);
		issue(dcm_ramp_pkg::OP_SOFT, dcm_ramp_pkg::DIR_CW, 7'd0);
		tick_burst(3);
		issue(dcm_ramp_pkg::OP_ESTOP, dcm_ramp_pkg::DIR_CW, 7'd0);
	endtask

	// Mostly well-formed ramps with random content, mixed with stops and noise.
	task automatic test_random(int n, logic [3:0] ramp, logic low_en, logic up_en);
		int r;
		write_reg(dcm_ramp_pkg::REG_RAMP_SETTING, ramp);
		write_reg(dcm_ramp_pkg::REG_LOWER_ENABLE, {3'd0, low_en});
		write_reg(dcm_ramp_pkg::REG_UPPER_ENABLE, {3'd0, up_en});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 79) == 0) idling = ~idling;
			if ($urandom_range(0, 59) == 0) settle();
			r = $urandom_range(0, 99);
			if (r < 40)
				tick_burst($urandom_range(1, 6));
			else if (r < 50)
				tick_burst($urandom_range(10, 40));
			else if (r < 80)
				issue(dcm_ramp_pkg::OP_GO, 1'($urandom),
					($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 3)) :
					7'($urandom_range(0, 127)));
			else if (r < 92)
				send_event(make_cmd(dcm_ramp_pkg::OP_SOFT));
			else
				send_event(make_cmd(dcm_ramp_pkg::OP_ESTOP));
		end
		idling = 1'b1;
	endtask

	// Receiver stalls: occasional, mostly short.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 15) == 0) begin
			stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) :
				$urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare each report against the oldest expectation.
	always @(posedge clk) begin : check_reports
		dcm_ramp_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (drive_report_q.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("%0t: report with nothing expected: %p", $realtime, rsp);
			end else begin
				want = drive_report_q.pop_front();
				if (rsp.first_drive_level !== want.first_drive_level ||
					rsp.second_drive_level !== want.second_drive_level ||
					rsp.motor_state !== want.motor_state ||
					rsp.run_status !== want.run_status ||
					rsp.motor_direction !== want.motor_direction) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: report mismatch: expected %p, got %p",
							$realtime, want, rsp);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_events();
		test_commands();
		test_limit_switches();
		test_ramp_timing();
		test_random(60, 4'd0, 1'b0, 1'b0);
		test_random(40, 4'd0, 1'b1, 1'b1);
		test_random(35, 4'd1, 1'b1, 1'b0);
		test_random(30, 4'd2, 1'b0, 1'b1);
		settle();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && drive_report_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/dcm_ramp_pkg.sv
src/dc_motor_soft_start_ramp_core.sv
dv/testbench.sv
